// ----- design/linked_deque_pool_core_macros.svh -----
// assertion macros used by the linked deque pool rtl
// expects clk and rst to be visible where a macro is used
`ifndef LINKED_DEQUE_POOL_CORE_MACROS_SVH
`define LINKED_DEQUE_POOL_CORE_MACROS_SVH

// property that must hold at every edge out of reset
`define LDP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("linked deque pool invariant violated");

// implication checked in the cycle after the antecedent
`define LDP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("linked deque pool sequence violated");

`endif

// ----- design/ldp_pkg.sv -----
// shared types and constants of the linked deque pool
// no dependencies
`default_nettype none

package ldp_pkg;

  localparam int LDP_POOL_DEPTH = 64;
  localparam int LDP_VALUE_BITS = 64;

  localparam int IN_W    = 80;
  localparam int OUT_W   = 80;
  localparam int MODE_W  = 3;
  localparam int VALUE_W = 64;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 6;
  localparam int LEN_W   = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_FIND       = 3'd4,
    MODE_INSERT     = 3'd5
  } ldp_mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } ldp_status_t;

  typedef enum logic [3:0] {
    CMD_NOP        = 4'd0,
    CMD_LOAD       = 4'd1,
    CMD_SCAN       = 4'd2,
    CMD_PUSH_A     = 4'd3,
    CMD_PUSH_B     = 4'd4,
    CMD_POP_RD     = 4'd5,
    CMD_POP_UPD    = 4'd6,
    CMD_WALK_START = 4'd7,
    CMD_FIND_STEP  = 4'd8,
    CMD_INS_STEP   = 4'd9,
    CMD_INS_A      = 4'd10,
    CMD_INS_B      = 4'd11,
    CMD_SET_EMPTY  = 4'd12,
    CMD_SET_MISS   = 4'd13,
    CMD_EMIT       = 4'd14
  } ldp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              head_nil;
    logic              tail_nil;
    logic              count_zero;
    logic              scan_hit;
    logic              scan_last;
    logic              find_done;
    logic              walk_done;
    logic              out_busy;
  } ldp_stat_t;

endpackage

`default_nettype wire

// ----- design/ldp_ctrl.sv -----
// request sequencer of the linked deque pool
// depends on ldp_pkg; drives datapath commands from datapath status
`default_nettype none

module ldp_ctrl
  import ldp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_axis_tvalid,
  output logic           s_axis_tready,
  input  wire ldp_stat_t stat,
  output ldp_cmd_t       cmd
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_DISPATCH  = 11'b000_0000_0010,
    S_SCAN      = 11'b000_0000_0100,
    S_PUSH_A    = 11'b000_0000_1000,
    S_PUSH_B    = 11'b000_0001_0000,
    S_POP_UPD   = 11'b000_0010_0000,
    S_FIND_WALK = 11'b000_0100_0000,
    S_INS_WALK  = 11'b000_1000_0000,
    S_INS_A     = 11'b001_0000_0000,
    S_INS_B     = 11'b010_0000_0000,
    S_FIN       = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;
  logic   is_push;

  assign s_axis_tready = (state == S_IDLE);
  assign is_push = (stat.mode == MODE_PUSH_FRONT) || (stat.mode == MODE_PUSH_BACK);

  always_comb begin
    state_next = state;
    cmd        = CMD_NOP;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd        = CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.mode)
          MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            state_next = S_SCAN;
          end
          MODE_POP_FRONT: begin
            cmd        = stat.head_nil ? CMD_SET_EMPTY : CMD_POP_RD;
            state_next = stat.head_nil ? S_FIN : S_POP_UPD;
          end
          MODE_POP_BACK: begin
            cmd        = stat.tail_nil ? CMD_SET_EMPTY : CMD_POP_RD;
            state_next = stat.tail_nil ? S_FIN : S_POP_UPD;
          end
          MODE_FIND: begin
            cmd        = stat.head_nil ? CMD_SET_MISS : CMD_WALK_START;
            state_next = stat.head_nil ? S_FIN : S_FIND_WALK;
          end
          MODE_INSERT: begin
            if (stat.head_nil || stat.count_zero) begin
              cmd        = CMD_SET_EMPTY;
              state_next = S_FIN;
            end else begin
              cmd        = CMD_WALK_START;
              state_next = S_INS_WALK;
            end
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        cmd = CMD_SCAN;
        if (stat.scan_hit) begin
          state_next = is_push ? S_PUSH_A : S_INS_A;
        end else if (stat.scan_last) begin
          state_next = S_FIN;
        end
      end
      S_PUSH_A: begin
        cmd        = CMD_PUSH_A;
        state_next = S_PUSH_B;
      end
      S_PUSH_B: begin
        cmd        = CMD_PUSH_B;
        state_next = S_FIN;
      end
      S_POP_UPD: begin
        cmd        = CMD_POP_UPD;
        state_next = S_FIN;
      end
      S_FIND_WALK: begin
        cmd = CMD_FIND_STEP;
        if (stat.find_done) begin
          state_next = S_FIN;
        end
      end
      S_INS_WALK: begin
        cmd = CMD_INS_STEP;
        if (stat.walk_done) begin
          state_next = S_SCAN;
        end
      end
      S_INS_A: begin
        cmd        = CMD_INS_A;
        state_next = S_INS_B;
      end
      S_INS_B: begin
        cmd        = CMD_INS_B;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd        = CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/ldp_dpath.sv -----
// node pool, links, free map and result register of the linked deque pool
// depends on ldp_pkg and linked_deque_pool_core_macros.svh; driven by ldp_ctrl
`default_nettype none
`include "linked_deque_pool_core_macros.svh"

module ldp_dpath
  import ldp_pkg::*;
#(
  parameter int POOL_DEPTH = LDP_POOL_DEPTH,
  parameter int VALUE_BITS = LDP_VALUE_BITS
)(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ldp_cmd_t         cmd,
  output ldp_stat_t             stat,
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata
);

  localparam int SW = $clog2(POOL_DEPTH);
  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam int PW = (LW > POS_W) ? LW : POS_W;
  localparam logic [LW-1:0] NIL = LW'(POOL_DEPTH);

  logic [VALUE_BITS-1:0] mem_val  [POOL_DEPTH];
  logic [LW-1:0]         mem_next [POOL_DEPTH];
  logic [LW-1:0]         mem_prev [POOL_DEPTH];

  logic [VALUE_BITS-1:0] rd_val;
  logic [LW-1:0]         rd_next, rd_prev;
  logic [SW-1:0]         raddr;

  logic                  v_we, n_we, p_we;
  logic [SW-1:0]         v_addr, n_addr, p_addr;
  logic [LW-1:0]         n_data, p_data;

  logic [MODE_W-1:0]     mode_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [LW-1:0]         pos_eff;
  logic [LW-1:0]         head, tail, count;
  logic [POOL_DEPTH-1:0] free;
  logic [SW-1:0]         scan, slot_s;
  logic [LW-1:0]         cur, link_n, link_p, walk_k;

  logic [STAT_W-1:0]            res_status;
  logic signed [VALUE_BITS-1:0] res_data;
  logic [SW-1:0]                res_slot;

  logic [POS_W-1:0]  in_pos;
  logic [PW-1:0]     pos_x, cnt_x;
  logic              is_front, pop_front;
  logic              match;

  assign in_pos    = s_axis_tdata[72:67];
  assign pos_x     = PW'(in_pos);
  assign cnt_x     = PW'(count);
  assign is_front  = (mode_r == MODE_PUSH_FRONT);
  assign pop_front = (mode_r == MODE_POP_FRONT);
  assign match     = (rd_val == val_r);

  assign stat.mode       = mode_r;
  assign stat.head_nil   = (head == NIL);
  assign stat.tail_nil   = (tail == NIL);
  assign stat.count_zero = (count == '0);
  assign stat.scan_hit   = free[scan];
  assign stat.scan_last  = (scan == SW'(POOL_DEPTH - 1));
  assign stat.find_done  = match || (rd_next == NIL);
  assign stat.walk_done  = (walk_k == pos_eff) || (rd_next == NIL);
  assign stat.out_busy   = m_axis_tvalid && !m_axis_tready;

  always_comb begin
    case (cmd)
      CMD_POP_RD:     raddr = pop_front ? head[SW-1:0] : tail[SW-1:0];
      CMD_WALK_START: raddr = head[SW-1:0];
      CMD_FIND_STEP,
      CMD_INS_STEP:   raddr = rd_next[SW-1:0];
      default:        raddr = cur[SW-1:0];
    endcase
  end

  always_comb begin
    v_we   = 1'b0;
    n_we   = 1'b0;
    p_we   = 1'b0;
    v_addr = slot_s;
    n_addr = slot_s;
    p_addr = slot_s;
    n_data = NIL;
    p_data = NIL;
    case (cmd)
      CMD_PUSH_A: begin
        v_we   = 1'b1;
        n_we   = 1'b1;
        p_we   = 1'b1;
        n_data = is_front ? head : NIL;
        p_data = is_front ? NIL : tail;
      end
      CMD_PUSH_B: begin
        if (is_front) begin
          p_we   = (head != NIL);
          p_addr = head[SW-1:0];
          p_data = LW'(slot_s);
        end else begin
          n_we   = (tail != NIL);
          n_addr = tail[SW-1:0];
          n_data = LW'(slot_s);
        end
      end
      CMD_POP_UPD: begin
        n_we   = (rd_prev != NIL);
        n_addr = rd_prev[SW-1:0];
        n_data = rd_next;
        p_we   = (rd_next != NIL);
        p_addr = rd_next[SW-1:0];
        p_data = rd_prev;
      end
      CMD_INS_A: begin
        v_we   = 1'b1;
        n_we   = 1'b1;
        p_we   = 1'b1;
        n_data = link_n;
        p_data = link_p;
      end
      CMD_INS_B: begin
        n_we   = 1'b1;
        n_addr = link_p[SW-1:0];
        n_data = LW'(slot_s);
        p_we   = (link_n != NIL);
        p_addr = link_n[SW-1:0];
        p_data = LW'(slot_s);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      mem_val[v_addr] <= val_r;
    end
    if (n_we) begin
      mem_next[n_addr] <= n_data;
    end
    if (p_we) begin
      mem_prev[p_addr] <= p_data;
    end
    rd_val  <= mem_val[raddr];
    rd_next <= mem_next[raddr];
    rd_prev <= mem_prev[raddr];
  end

  // working registers and result
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        mode_r     <= s_axis_tdata[2:0];
        val_r      <= s_axis_tdata[3 +: VALUE_BITS];
        scan       <= '0;
        res_status <= ST_OK;
        res_data   <= '0;
        res_slot   <= '0;
        if (count == '0) begin
          pos_eff <= '0;
        end else if (pos_x >= cnt_x) begin
          pos_eff <= count - 1'b1;
        end else begin
          pos_eff <= LW'(in_pos);
        end
      end
      CMD_SCAN: begin
        scan <= scan + 1'b1;
        if (free[scan]) begin
          slot_s <= scan;
        end else if (scan == SW'(POOL_DEPTH - 1)) begin
          res_status <= ST_FULL;
        end
      end
      CMD_PUSH_B,
      CMD_INS_B: begin
        res_slot <= slot_s;
      end
      CMD_POP_RD: begin
        slot_s <= pop_front ? head[SW-1:0] : tail[SW-1:0];
      end
      CMD_POP_UPD: begin
        res_data <= rd_val;
      end
      CMD_WALK_START: begin
        cur    <= head;
        walk_k <= '0;
      end
      CMD_FIND_STEP: begin
        cur <= rd_next;
        if (match) begin
          res_data <= val_r;
          res_slot <= cur[SW-1:0];
        end else if (rd_next == NIL) begin
          res_status <= ST_NOTFOUND;
        end
      end
      CMD_INS_STEP: begin
        if ((walk_k == pos_eff) || (rd_next == NIL)) begin
          link_p <= cur;
          link_n <= rd_next;
        end else begin
          cur    <= rd_next;
          walk_k <= walk_k + 1'b1;
        end
      end
      CMD_SET_EMPTY: begin
        res_status <= ST_EMPTY;
      end
      CMD_SET_MISS: begin
        res_status <= ST_NOTFOUND;
      end
      default: begin
      end
    endcase
  end

  // list anchors, count and free map
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= NIL;
      tail  <= NIL;
      count <= '0;
      free  <= '1;
    end else begin
      case (cmd)
        CMD_PUSH_B: begin
          if (is_front) begin
            if (head == NIL) begin
              tail <= LW'(slot_s);
            end
            head <= LW'(slot_s);
          end else begin
            if (tail == NIL) begin
              head <= LW'(slot_s);
            end
            tail <= LW'(slot_s);
          end
          count        <= count + 1'b1;
          free[slot_s] <= 1'b0;
        end
        CMD_POP_UPD: begin
          if (rd_prev == NIL) begin
            head <= rd_next;
          end
          if (rd_next == NIL) begin
            tail <= rd_prev;
          end
          if (count != '0) begin
            count <= count - 1'b1;
          end
          free[slot_s] <= 1'b1;
        end
        CMD_INS_B: begin
          if (link_n == NIL) begin
            tail <= LW'(slot_s);
          end
          count        <= count + 1'b1;
          free[slot_s] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd == CMD_EMIT) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_EMIT) begin
      m_axis_tdata <= {1'b0, LEN_W'(count), SLOT_W'(res_slot), VALUE_W'(res_data),
                       res_status};
    end
  end

  `LDP_ASSERT_ALWAYS(a_head_vs_count, (head == NIL) == (count == '0))
  `LDP_ASSERT_ALWAYS(a_head_vs_tail, (head == NIL) == (tail == NIL))
  `LDP_ASSERT_ALWAYS(a_count_bound, count <= LW'(POOL_DEPTH))
  `LDP_ASSERT_NEXT(a_push_grows, cmd == CMD_PUSH_B, count == $past(count) + 1'b1)

endmodule

`default_nettype wire

// ----- design/linked_deque_pool_core.sv -----
// linked deque pool: a doubly linked list of signed values in a fixed node pool
// input words on s_axis (one request each), result words on m_axis (one per request)
// each request is taken only while the block is idle; the result sits in an
// output register, so the next request is taken while that word waits
// after accept the request is decoded, then by mode:
//   pop reads the end node and relinks its neighbours, an unused mode goes
//   straight to the result, push scans for a free slot (one slot per cycle)
//   and then writes and links the node, push on a full pool scans every slot,
//   find walks one node per cycle through the link memory read port, insert
//   walks to its position, scans for a free slot, then writes and links the node
// reset empties the list and frees every slot; node memories are not cleared
// a stalled m_axis holds the finished word; a later result waits in the last
// step until that word is taken
// depends on ldp_pkg, ldp_ctrl, ldp_dpath
`default_nettype none

module linked_deque_pool_core
  import ldp_pkg::*;
#(
  parameter int POOL_DEPTH = LDP_POOL_DEPTH,
  parameter int VALUE_BITS = LDP_VALUE_BITS
)(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,  // mode, value, position, pad
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata   // status, data_out, node_slot, length, pad
);

  ldp_cmd_t  cmd;
  ldp_stat_t stat;

  ldp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  ldp_dpath #(
    .POOL_DEPTH (POOL_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire
